// ===== hdl/smmm_pkg.sv =====
// Package for the stack with min/max/mean unit: sizes, command codes,
// microcode word layout and the microcode ROM.
// No dependencies.
package smmm_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int MEAN_W      = 40;
   localparam int HELD_W      = 7;
   localparam int CMD_W       = 2;
   localparam int FRAC_W      = 8;
   localparam int SUM_W       = DATA_W + CNT_W;
   localparam int DIVD_W      = SUM_W + FRAC_W;
   localparam int DIVC_W      = $clog2(DIVD_W);
   localparam int UPC_W       = 4;

   typedef logic [UPC_W-1:0]  upc_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DIVC_W-1:0] divc_type;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STAT = 2'd2;

   // next-address modes
   localparam logic [1:0] NX_JUMP     = 2'd0;
   localparam logic [1:0] NX_SEQ      = 2'd1;
   localparam logic [1:0] NX_DISPATCH = 2'd2;
   localparam logic [1:0] NX_EMIT     = 2'd3;

   // jump conditions
   localparam logic [1:0] COND_ALWAYS   = 2'd0;
   localparam logic [1:0] COND_IDX_MORE = 2'd1;
   localparam logic [1:0] COND_DIV_MORE = 2'd2;

   // result kinds
   localparam logic [1:0] OUT_FAIL = 2'd0;
   localparam logic [1:0] OUT_PUSH = 2'd1;
   localparam logic [1:0] OUT_POP  = 2'd2;
   localparam logic [1:0] OUT_STAT = 2'd3;

   // microprogram addresses
   localparam upc_type S_IDLE       = 4'd0;
   localparam upc_type S_PUSH       = 4'd1;
   localparam upc_type S_EMIT_PUSH  = 4'd2;
   localparam upc_type S_POP        = 4'd3;
   localparam upc_type S_EMIT_POP   = 4'd4;
   localparam upc_type S_EMIT_FAIL  = 4'd5;
   localparam upc_type S_STAT_CLR   = 4'd6;
   localparam upc_type S_STAT_RD    = 4'd7;
   localparam upc_type S_STAT_DRAIN = 4'd8;
   localparam upc_type S_DIV_INIT   = 4'd9;
   localparam upc_type S_DIV_STEP   = 4'd10;
   localparam upc_type S_EMIT_STAT  = 4'd11;

   typedef struct packed {
      logic [1:0] nx;
      logic [1:0] cond;
      upc_type    target;
      logic       mem_wr;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rd_top;
      logic       rd_idx;
      logic       stat_clr;
      logic       div_init;
      logic       div_step;
      logic [1:0] out_sel;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input upc_type step);
      ctrl_word_type w;
      w = '0;
      unique case (step)
         S_IDLE:       w.nx = NX_DISPATCH;
         S_PUSH: begin
            w.nx      = NX_SEQ;
            w.mem_wr  = 1'b1;
            w.cnt_inc = 1'b1;
         end
         S_EMIT_PUSH: begin
            w.nx      = NX_EMIT;
            w.out_sel = OUT_PUSH;
         end
         S_POP: begin
            w.nx      = NX_SEQ;
            w.cnt_dec = 1'b1;
            w.rd_top  = 1'b1;
         end
         S_EMIT_POP: begin
            w.nx      = NX_EMIT;
            w.out_sel = OUT_POP;
         end
         S_EMIT_FAIL: begin
            w.nx      = NX_EMIT;
            w.out_sel = OUT_FAIL;
         end
         S_STAT_CLR: begin
            w.nx       = NX_SEQ;
            w.stat_clr = 1'b1;
         end
         S_STAT_RD: begin
            w.nx     = NX_JUMP;
            w.cond   = COND_IDX_MORE;
            w.target = S_STAT_RD;
            w.rd_idx = 1'b1;
         end
         S_STAT_DRAIN: w.nx = NX_SEQ;
         S_DIV_INIT: begin
            w.nx       = NX_SEQ;
            w.div_init = 1'b1;
         end
         S_DIV_STEP: begin
            w.nx       = NX_JUMP;
            w.cond     = COND_DIV_MORE;
            w.target   = S_DIV_STEP;
            w.div_step = 1'b1;
         end
         S_EMIT_STAT: begin
            w.nx      = NX_EMIT;
            w.out_sel = OUT_STAT;
         end
         default: begin
            w.nx     = NX_JUMP;
            w.cond   = COND_ALWAYS;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/stack_with_min_max_mean_unit.sv =====
// Top level of the stack with min/max/mean unit: microcoded sequencer,
// stack memory, statistics accumulator and restoring divider.
// Depends on smmm_pkg.
//
//   channel  dir  handshake                 payload
//   req_     in   req_valid / req_stall     req_command, req_value
//   rsp_     out  rsp_valid / rsp_stall     rsp_ok, rsp_popped_value, rsp_largest,
//                                           rsp_smallest, rsp_mean_q8, rsp_entries_held
//
// Push and pop: dispatch, memory access and result load, in that order, from accepted
// beat to result register. Statistics over N held entries run the one-entry-per-cycle
// memory read loop and then the one-bit-per-cycle divider (DIVD_W = 47 at depth 64).
// A failing command (full push, empty pop or statistics, unused code) goes from dispatch straight to result load.
// Synchronous active-high reset empties the stack; memory contents are not cleared.
// A new beat is taken only in the idle step; a held result stalls the sequencer
// in its load step until the result register frees.
module stack_with_min_max_mean_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [smmm_pkg::CMD_W-1:0]           req_command,
   input  logic signed [smmm_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [smmm_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic signed [smmm_pkg::DATA_W-1:0]   rsp_largest,
   output logic signed [smmm_pkg::DATA_W-1:0]   rsp_smallest,
   output logic signed [smmm_pkg::MEAN_W-1:0]   rsp_mean_q8,
   output logic [smmm_pkg::HELD_W-1:0]          rsp_entries_held
);

   smmm_pkg::ctrl_word_type ctrl;

   smmm_pkg::upc_type  upc_ff, upc_in, dispatch;
   smmm_pkg::cnt_type  cnt_ff, idx_ff, top_m1;
   smmm_pkg::divc_type div_cnt_ff;

   logic [smmm_pkg::DATA_W-1:0] stack_mem [smmm_pkg::STACK_DEPTH];
   logic [smmm_pkg::DATA_W-1:0] val_ff, rd_data_ff;
   logic [smmm_pkg::PTR_W-1:0]  rd_addr;

   logic signed [smmm_pkg::DATA_W-1:0] max_ff, min_ff, x;
   logic signed [smmm_pkg::SUM_W-1:0]  sum_ff;
   logic [smmm_pkg::DIVD_W-1:0]        scaled, q_ff;
   logic [smmm_pkg::CNT_W-1:0]         rem_ff;
   logic [smmm_pkg::CNT_W:0]           rem_sh, rem_diff;
   logic [smmm_pkg::MEAN_W-1:0]        q_lo, mean;
   logic                               neg_ff, acc_pend_ff;

   logic req_accept, out_free, out_load, cond_true, rd_en, full, empty;

   logic                               rsp_valid_ff, rsp_ok_ff;
   logic signed [smmm_pkg::DATA_W-1:0] rsp_popped_ff, rsp_largest_ff, rsp_smallest_ff;
   logic signed [smmm_pkg::MEAN_W-1:0] rsp_mean_ff;
   logic [smmm_pkg::HELD_W-1:0]        rsp_held_ff;

   assign req_stall  = (upc_ff != smmm_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign full       = (cnt_ff == smmm_pkg::cnt_type'(smmm_pkg::STACK_DEPTH));
   assign empty      = (cnt_ff == '0);
   assign top_m1     = cnt_ff - smmm_pkg::cnt_type'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign out_load   = (ctrl.nx == smmm_pkg::NX_EMIT) && out_free;
   assign rd_en      = ctrl.rd_top || ctrl.rd_idx;
   assign rd_addr    = ctrl.rd_top ? top_m1[smmm_pkg::PTR_W-1:0]
                                   : idx_ff[smmm_pkg::PTR_W-1:0];
   assign x          = signed'(rd_data_ff);

   // sequencer
   always_comb begin
      ctrl = smmm_pkg::ucode(upc_ff);

      unique case (req_command)
         smmm_pkg::CMD_PUSH: dispatch = full  ? smmm_pkg::S_EMIT_FAIL : smmm_pkg::S_PUSH;
         smmm_pkg::CMD_POP:  dispatch = empty ? smmm_pkg::S_EMIT_FAIL : smmm_pkg::S_POP;
         smmm_pkg::CMD_STAT: dispatch = empty ? smmm_pkg::S_EMIT_FAIL
                                              : smmm_pkg::S_STAT_CLR;
         default:            dispatch = smmm_pkg::S_EMIT_FAIL;
      endcase

      case (ctrl.cond)
         smmm_pkg::COND_IDX_MORE: cond_true = (idx_ff != top_m1);
         smmm_pkg::COND_DIV_MORE: cond_true = (div_cnt_ff != '0);
         default:                 cond_true = 1'b1;
      endcase

      unique case (ctrl.nx)
         smmm_pkg::NX_JUMP:     upc_in = cond_true ? ctrl.target
                                                   : upc_ff + smmm_pkg::upc_type'(1);
         smmm_pkg::NX_SEQ:      upc_in = upc_ff + smmm_pkg::upc_type'(1);
         smmm_pkg::NX_DISPATCH: upc_in = req_accept ? dispatch : smmm_pkg::S_IDLE;
         default:               upc_in = out_free ? smmm_pkg::S_IDLE : upc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= smmm_pkg::S_IDLE;
         cnt_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         if (ctrl.cnt_inc)
            cnt_ff <= cnt_ff + smmm_pkg::cnt_type'(1);
         else if (ctrl.cnt_dec)
            cnt_ff <= top_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept)
         val_ff <= req_value;
   end

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.mem_wr)
         stack_mem[cnt_ff[smmm_pkg::PTR_W-1:0]] <= val_ff;
      if (rd_en)
         rd_data_ff <= stack_mem[rd_addr];
   end

   // statistics walk: read data is registered, so it is accumulated in the cycle after its address
   always_ff @(posedge clock) begin
      if (reset)
         acc_pend_ff <= 1'b0;
      else
         acc_pend_ff <= ctrl.rd_idx;
   end

   always_ff @(posedge clock) begin
      if (ctrl.stat_clr) begin
         idx_ff <= '0;
         sum_ff <= '0;
         max_ff <= {1'b1, {(smmm_pkg::DATA_W-1){1'b0}}};
         min_ff <= {1'b0, {(smmm_pkg::DATA_W-1){1'b1}}};
      end else begin
         if (ctrl.rd_idx)
            idx_ff <= idx_ff + smmm_pkg::cnt_type'(1);
         if (acc_pend_ff) begin
            sum_ff <= sum_ff + smmm_pkg::SUM_W'(x);
            if (x > max_ff) max_ff <= x;
            if (x < min_ff) min_ff <= x;
         end
      end
   end

   // restoring divide of |sum * 256| by the entry count, one bit per step
   assign scaled   = {sum_ff, {smmm_pkg::FRAC_W{1'b0}}};
   assign rem_sh   = {rem_ff, q_ff[smmm_pkg::DIVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, cnt_ff};
   assign q_lo     = q_ff[smmm_pkg::MEAN_W-1:0];
   assign mean     = neg_ff ? (smmm_pkg::MEAN_W'(0) - q_lo) : q_lo;

   always_ff @(posedge clock) begin
      if (ctrl.div_init) begin
         neg_ff     <= sum_ff[smmm_pkg::SUM_W-1];
         q_ff       <= sum_ff[smmm_pkg::SUM_W-1] ? (smmm_pkg::DIVD_W'(0) - scaled) : scaled;
         rem_ff     <= '0;
         div_cnt_ff <= smmm_pkg::divc_type'(smmm_pkg::DIVD_W - 1);
      end else if (ctrl.div_step) begin
         div_cnt_ff <= div_cnt_ff - smmm_pkg::divc_type'(1);
         if (!rem_diff[smmm_pkg::CNT_W]) begin
            rem_ff <= rem_diff[smmm_pkg::CNT_W-1:0];
            q_ff   <= {q_ff[smmm_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[smmm_pkg::CNT_W-1:0];
            q_ff   <= {q_ff[smmm_pkg::DIVD_W-2:0], 1'b0};
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ok_ff       <= 1'b0;
         rsp_popped_ff   <= '0;
         rsp_largest_ff  <= '0;
         rsp_smallest_ff <= '0;
         rsp_mean_ff     <= '0;
         rsp_held_ff     <= smmm_pkg::HELD_W'(cnt_ff);
         case (ctrl.out_sel)
            smmm_pkg::OUT_PUSH: rsp_ok_ff <= 1'b1;
            smmm_pkg::OUT_POP: begin
               rsp_ok_ff     <= 1'b1;
               rsp_popped_ff <= x;
            end
            smmm_pkg::OUT_STAT: begin
               rsp_ok_ff       <= 1'b1;
               rsp_largest_ff  <= max_ff;
               rsp_smallest_ff <= min_ff;
               rsp_mean_ff     <= signed'(mean);
            end
            default: rsp_ok_ff <= 1'b0;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_largest      = rsp_largest_ff;
   assign rsp_smallest     = rsp_smallest_ff;
   assign rsp_mean_q8      = rsp_mean_ff;
   assign rsp_entries_held = rsp_held_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= smmm_pkg::cnt_type'(smmm_pkg::STACK_DEPTH))
      else $error("fill count beyond depth");

   a_wr_not_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.mem_wr |-> !full)
      else $error("write to full stack");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == smmm_pkg::S_STAT_RD) |-> (idx_ff < cnt_ff))
      else $error("statistics walk past top");

   a_stat_order: assert property (@(posedge clock) disable iff (reset)
      (out_load && ctrl.out_sel == smmm_pkg::OUT_STAT) |=> (rsp_largest_ff >= rsp_smallest_ff))
      else $error("largest below smallest");

endmodule
